// ----- src/ihexld_pkg.sv -----
package ihexld_pkg;

   // Result kinds carried on the result channel's tuser.
   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // Record types of the hex format.
   localparam logic [7:0] REC_DATA      = 8'h00;
   localparam logic [7:0] REC_EOF       = 8'h01;
   localparam logic [7:0] REC_SEG_BASE  = 8'h02;
   localparam logic [7:0] REC_SEG_START = 8'h03;
   localparam logic [7:0] REC_LIN_BASE  = 8'h04;
   localparam logic [7:0] REC_LIN_START = 8'h05;

   localparam logic [7:0] CHAR_COLON = 8'h3A;

   // Parser phase, one-hot.
   typedef enum logic [7:0] {
      PH_COLON = 8'b0000_0001,
      PH_LEN   = 8'b0000_0010,
      PH_ADDR  = 8'b0000_0100,
      PH_TYPE  = 8'b0000_1000,
      PH_DATA  = 8'b0001_0000,
      PH_SUM   = 8'b0010_0000,
      PH_GAP   = 8'b0100_0000,
      PH_HALT  = 8'b1000_0000
   } phase_type;

   // One result item as it leaves the parser.
   typedef struct packed {
      logic        valid;
      logic [1:0]  kind;
      logic [63:0] address;
      logic [7:0]  data_byte;
   } result_type;

   // Value of one hex digit; anything that is not a hex digit counts as zero.
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      v = 8'd0;
      case (c) inside
         [8'h30:8'h39]: v = c - 8'h30;
         [8'h61:8'h66]: v = c - 8'h57;
         [8'h41:8'h46]: v = c - 8'h37;
         default:       v = 8'd0;
      endcase
      return v[3:0];
   endfunction

endpackage

// ----- src/ihexld_parser.sv -----
module ihexld_parser
   import ihexld_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] character,
   output result_type result
);

   phase_type   phase_ff, phase_in;
   logic [1:0]  digit_count_ff, digit_count_in;
   logic [15:0] field_acc_ff, field_acc_in;
   logic [3:0]  high_nibble_ff, high_nibble_in;
   logic [7:0]  record_length_ff, record_length_in;
   logic [15:0] record_offset_ff, record_offset_in;
   logic [7:0]  record_kind_ff, record_kind_in;
   logic [7:0]  byte_index_ff, byte_index_in;
   logic [63:0] base_address_ff, base_address_in;
   logic [63:0] start_acc_ff, start_acc_in;

   logic [3:0]  digit;
   logic        byte_done;
   logic [7:0]  byte_value;
   logic [63:0] write_address;
   logic [15:0] acc_shifted;

   assign digit         = hex_value(character);
   assign byte_done     = (digit_count_ff != 2'd0);
   assign byte_value    = {high_nibble_ff, digit};
   assign acc_shifted   = {field_acc_ff[11:0], digit};
   assign write_address = (base_address_ff | {48'd0, record_offset_ff})
                          + {56'd0, byte_index_ff};

   // Next-state and result logic for one character.
   always_comb begin
      phase_in         = phase_ff;
      digit_count_in   = digit_count_ff;
      field_acc_in     = field_acc_ff;
      high_nibble_in   = high_nibble_ff;
      record_length_in = record_length_ff;
      record_offset_in = record_offset_ff;
      record_kind_in   = record_kind_ff;
      byte_index_in    = byte_index_ff;
      base_address_in  = base_address_ff;
      start_acc_in     = start_acc_ff;
      result           = '0;

      // Shared two-digit byte field handling.
      if (phase_ff == PH_LEN || phase_ff == PH_TYPE || phase_ff == PH_DATA ||
          phase_ff == PH_SUM) begin
         if (byte_done) begin
            digit_count_in = 2'd0;
         end else begin
            high_nibble_in = digit;
            digit_count_in = 2'd1;
         end
      end

      case (phase_ff)
         PH_COLON: begin
            if (!(character inside {8'h20, [8'h09:8'h0D]})) begin
               if (character != CHAR_COLON) begin
                  phase_in     = PH_HALT;
                  result.valid = 1'b1;
                  result.kind  = KIND_ERROR;
               end else begin
                  digit_count_in = 2'd0;
                  field_acc_in   = 16'd0;
                  phase_in       = PH_LEN;
               end
            end
         end
         PH_LEN: begin
            if (byte_done) begin
               record_length_in = byte_value;
               phase_in         = PH_ADDR;
            end
         end
         PH_ADDR: begin
            field_acc_in = acc_shifted;
            if (digit_count_ff == 2'd3) begin
               digit_count_in   = 2'd0;
               record_offset_in = acc_shifted;
               field_acc_in     = 16'd0;
               phase_in         = PH_TYPE;
            end else begin
               digit_count_in = digit_count_ff + 2'd1;
            end
         end
         PH_TYPE: begin
            if (byte_done) begin
               record_kind_in = byte_value;
               byte_index_in  = 8'd0;
               if (byte_value == REC_SEG_BASE || byte_value == REC_LIN_BASE) begin
                  base_address_in = 64'd0;
               end
               if (byte_value == REC_LIN_START) begin
                  start_acc_in = 64'd0;
               end
               if (byte_value == REC_EOF || record_length_ff == 8'd0) begin
                  phase_in = PH_SUM;
               end else begin
                  phase_in = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            if (byte_done) begin
               case (record_kind_ff)
                  REC_DATA: begin
                     result.valid     = 1'b1;
                     result.kind      = KIND_WRITE;
                     result.address   = write_address;
                     result.data_byte = byte_value;
                  end
                  REC_SEG_BASE: begin
                     base_address_in = {base_address_ff[55:0], 8'd0}
                                       | {52'd0, byte_value, 4'd0};
                  end
                  REC_LIN_BASE: begin
                     base_address_in = {base_address_ff[55:0], 8'd0}
                                       | {40'd0, byte_value, 16'd0};
                  end
                  REC_LIN_START: begin
                     start_acc_in = {start_acc_ff[55:0], byte_value};
                  end
                  default: begin
                     // Start segment and unknown records drop their data.
                  end
               endcase
               if ({1'b0, byte_index_ff} + 9'd1 >= {1'b0, record_length_ff}) begin
                  phase_in = PH_SUM;
               end
               byte_index_in = byte_index_ff + 8'd1;
            end
         end
         PH_SUM: begin
            // The checksum is consumed but not checked.
            if (byte_done) begin
               if (record_kind_ff == REC_EOF) begin
                  phase_in       = PH_HALT;
                  result.valid   = 1'b1;
                  result.kind    = KIND_END;
                  result.address = start_acc_ff;
               end else begin
                  phase_in = PH_GAP;
               end
            end
         end
         PH_GAP: begin
            // The character after the checksum is dropped, whatever it is.
            phase_in = PH_COLON;
         end
         default: begin
            phase_in = PH_HALT;
         end
      endcase

      if (!step) begin
         result.valid = 1'b0;
      end
   end

   // Parser state advances once per transfer that reaches this stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_COLON;
         digit_count_ff   <= 2'd0;
         field_acc_ff     <= 16'd0;
         high_nibble_ff   <= 4'd0;
         record_length_ff <= 8'd0;
         record_offset_ff <= 16'd0;
         record_kind_ff   <= 8'd0;
         byte_index_ff    <= 8'd0;
         base_address_ff  <= 64'd0;
         start_acc_ff     <= 64'd0;
      end else if (step) begin
         phase_ff         <= phase_in;
         digit_count_ff   <= digit_count_in;
         field_acc_ff     <= field_acc_in;
         high_nibble_ff   <= high_nibble_in;
         record_length_ff <= record_length_in;
         record_offset_ff <= record_offset_in;
         record_kind_ff   <= record_kind_in;
         byte_index_ff    <= byte_index_in;
         base_address_ff  <= base_address_in;
         start_acc_ff     <= start_acc_in;
      end
   end

   // Once halted, the parser stays halted and produces nothing.
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HALT |=> phase_ff == PH_HALT)
      else $error("parser left the halted phase");

   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HALT |-> !result.valid)
      else $error("result produced while halted");

   a_end_from_sum: assert property (@(posedge clock) disable iff (reset)
      (result.valid && result.kind == KIND_END) |-> phase_ff == PH_SUM)
      else $error("end result outside the checksum phase");

   a_write_from_data: assert property (@(posedge clock) disable iff (reset)
      (result.valid && result.kind == KIND_WRITE) |->
      (phase_ff == PH_DATA && record_kind_ff == REC_DATA))
      else $error("byte write outside a data record");

endmodule

// ----- src/ihexld_out_reg.sv -----
module ihexld_out_reg
   import ihexld_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  result_type  result,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [1:0]  out_kind,
   output logic [63:0] out_address,
   output logic [7:0]  out_data_byte
);

   logic        valid_ff, valid_in;
   logic [1:0]  kind_ff;
   logic [63:0] address_ff;
   logic [7:0]  data_ff;

   // A step replaces the held result; otherwise a taken transfer empties it.
   assign valid_in = step ? result.valid : (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && result.valid) begin
         kind_ff    <= result.kind;
         address_ff <= result.address;
         data_ff    <= result.data_byte;
      end
   end

   assign out_valid     = valid_ff;
   assign out_kind      = kind_ff;
   assign out_address   = address_ff;
   assign out_data_byte = data_ff;

   // The parser may only step when the held result is gone or being taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      step |-> (!valid_ff || out_ready))
      else $error("held result overwritten before its transfer");

   // An error result always carries a zero address and data byte.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff == KIND_ERROR) |-> (address_ff == 64'd0 && data_ff == 8'd0))
      else $error("error result with nonzero payload");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> kind_ff != 2'd3)
      else $error("result with an unused kind code");

endmodule

// ----- src/intel_hex_record_loader_core.sv -----
// Channel   Direction  Ports                       Payload
// req       in         req_tvalid/tready/tdata     tdata[7:0] character
// rsp       out        rsp_tvalid/tready/tdata     tdata[63:0] address, [71:64] data_byte;
//                      rsp_tuser                   tuser[1:0] kind
//
// One character is taken per cycle while rsp is not stalled. A character passes an input
// register, then the parser logic and the result register, which offers its result on rsp.
// Reset is synchronous and clears the parser to wait for a colon.
// A stalled result stops the parser stage; the input register then holds one more
// character before req_tready drops.
module intel_hex_record_loader_core
   import ihexld_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] character
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [63:0] address, [71:64] data_byte
   output logic [1:0]  rsp_tuser    // [1:0] kind
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       step;
   result_type result;
   logic [1:0]  out_kind;
   logic [63:0] out_address;
   logic [7:0]  out_data_byte;

   // The parser moves when a character is held and the result slot can take a result.
   assign step       = in_valid_ff && (!rsp_tvalid || rsp_tready);
   assign req_tready = !in_valid_ff || step;

   // Input register.
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
      end
   end

   ihexld_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .character (in_char_ff),
      .result    (result)
   );

   ihexld_out_reg u_out_reg (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .result        (result),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_kind      (out_kind),
      .out_address   (out_address),
      .out_data_byte (out_data_byte)
   );

   assign rsp_tdata = {out_data_byte, out_address};
   assign rsp_tuser = out_kind;

endmodule
